[hdl/wclm_pkg.sv]
// Package for the French word-clock LED mask block: sizes, the LED word type
// and the constant word tables. No dependencies.
`default_nettype none

package wclm_pkg;

  localparam int ROW_COUNT = 13;
  localparam int ROW_WIDTH = 15;
  localparam int ROW_IDX_W = 4;

  localparam logic [ROW_IDX_W-1:0] LAST_ROW = ROW_IDX_W'(ROW_COUNT - 1);

  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINUTE_MAX = 6'd59;
  localparam logic [5:0] MINUTES_PER_HOUR = 6'd60;
  localparam logic [5:0] MOINS_FROM = 6'd40;

  typedef struct packed {
    logic [ROW_IDX_W-1:0] row;
    logic [ROW_WIDTH-1:0] bits;
  } led_word_t;

  typedef logic [ROW_COUNT-1:0][ROW_WIDTH-1:0] led_mask_t;

  localparam led_word_t W_IT_IS   = '{4'd0,  15'h3700};
  localparam led_word_t W_NOON    = '{4'd1,  15'h001E};
  localparam led_word_t W_HEURE   = '{4'd4,  15'h7C00};
  localparam led_word_t W_HEURES  = '{4'd4,  15'h7E00};
  localparam led_word_t W_MOINS   = '{4'd4,  15'h001F};
  localparam led_word_t W_ET_HOUR = '{4'd4,  15'h0060};
  localparam led_word_t W_LE      = '{4'd5,  15'h6000};
  localparam led_word_t W_ET      = '{4'd7,  15'h0600};
  localparam led_word_t W_DEMI    = '{4'd7,  15'h01E0};
  localparam led_word_t W_MINUTES = '{4'd12, 15'h00FE};
  localparam led_word_t W_MINUTE  = '{4'd12, 15'h00FC};

  // Hour words for hour modulo twelve; entry zero is minuit.
  localparam led_word_t W_HOUR [12] = '{
    '{4'd2, 15'h7E00}, '{4'd3, 15'h7000}, '{4'd0, 15'h0078}, '{4'd1, 15'h0F80},
    '{4'd2, 15'h003F}, '{4'd2, 15'h01E0}, '{4'd1, 15'h00E0}, '{4'd1, 15'h7800},
    '{4'd3, 15'h000F}, '{4'd3, 15'h0F00}, '{4'd1, 15'h0007}, '{4'd3, 15'h00F0}
  };

  // Units one through nine, indexed by unit minus one.
  localparam led_word_t W_UNIT [9] = '{
    '{4'd11, 15'h7000}, '{4'd7, 15'h000F}, '{4'd9, 15'h007C}, '{4'd8, 15'h7E00},
    '{4'd10, 15'h3C00}, '{4'd9, 15'h0007}, '{4'd8, 15'h01E0}, '{4'd9, 15'h03C0},
    '{4'd11, 15'h000F}
  };

  // Ten through sixteen, indexed by value minus ten.
  localparam led_word_t W_TEENS [7] = '{
    '{4'd7, 15'h7000}, '{4'd12, 15'h3C00}, '{4'd9, 15'h7C00}, '{4'd8, 15'h003F},
    '{4'd11, 15'h0FF0}, '{4'd10, 15'h07C0}, '{4'd10, 15'h001F}
  };

  // Tens ten through fifty at index one to five; index zero lights nothing.
  localparam led_word_t W_TENS [6] = '{
    '{4'd0, 15'h0000}, '{4'd7, 15'h7000}, '{4'd5, 15'h001F}, '{4'd6, 15'h003F},
    '{4'd5, 15'h1FE0}, '{4'd6, 15'h7FC0}
  };

endpackage : wclm_pkg

`default_nettype wire

[hdl/word_clock_led_mask.sv]
// Top level of the French word-clock LED mask block: request register, row
// sequencer and output register. Depends on wclm_pkg and wclm_mask.
//
// Usage: a request carries hour_of_day (0-23) and minute_of_hour (0-59) on
// the input channel (in_valid/in_ready). Larger values are clamped to 23 and
// 59. For each request the block returns thirteen results on the output
// channel (out_valid/out_ready), rows 0 to 12 in order, each with row_index,
// the row's 15 LEDs in row_bits (set where lit; bit 14 is the leftmost
// column) and last_row set on row 12.
// Row 0 is loaded into the output register after the request has entered the
// request register, and further rows follow one per cycle while the receiver
// takes them, from the single output register; the next request is taken on
// the same edge that loads row 12, so frames follow each other with no gap.
// enable_demi is written through cfg_we/cfg_wdata, by the user only while the
// block is idle; the block itself does not enforce this. Reset sets it to 1
// (half past reads demi).
// Reset (rst, synchronous) drops any request in flight and empties the
// output register. When the receiver stalls, the current row holds in the
// output register and the sequencer waits; a new request is then refused
// until the frame in progress has reached its last row.
`default_nettype none

module word_clock_led_mask (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [4:0]  hour_of_day,
  input  wire logic [5:0]  minute_of_hour,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       row_index,
  output logic [14:0]      row_bits,
  output logic             last_row
);

  // Configuration register.
  logic enable_demi;

  // Request register holding the clamped time and the row being emitted.
  logic                           item_valid;
  logic [4:0]                     item_hour;
  logic [5:0]                     item_minute;
  logic [wclm_pkg::ROW_IDX_W-1:0] row;

  logic                           accept;
  logic                           load;
  logic                           at_last;
  logic [wclm_pkg::ROW_WIDTH-1:0] mask_row;

  // A row moves into the output register whenever that register is free or
  // its current row is being taken this cycle.
  assign load    = item_valid && (!out_valid || out_ready);
  assign at_last = (row == wclm_pkg::LAST_ROW);
  assign in_ready = !item_valid || (load && at_last);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_demi <= 1'b1;
    end else if (cfg_we) begin
      enable_demi <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      row        <= '0;
    end else begin
      if (load) begin
        row <= at_last ? '0 : row + 1'b1;
      end
      if (accept) begin
        item_valid <= 1'b1;
      end else if (load && at_last) begin
        item_valid <= 1'b0;
      end
    end
  end

  // Clamp the time on the way in so the decoder sees only legal values.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_hour   <= (hour_of_day > wclm_pkg::HOUR_MAX) ? wclm_pkg::HOUR_MAX : hour_of_day;
      item_minute <= (minute_of_hour > wclm_pkg::MINUTE_MAX) ?
                     wclm_pkg::MINUTE_MAX : minute_of_hour;
    end
  end

  wclm_mask u_mask (
    .hour        (item_hour),
    .minute      (item_minute),
    .enable_demi (enable_demi),
    .row         (row),
    .row_bits    (mask_row)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      row_index <= row;
      row_bits  <= mask_row;
      last_row  <= at_last;
    end
  end

endmodule : word_clock_led_mask

`default_nettype wire

[hdl/wclm_mask.sv]
// Combinational word decoder: builds the full LED mask for one time of day
// and selects one row of it. Depends on wclm_pkg.
`default_nettype none

module wclm_mask (
  input  wire logic [4:0]                     hour,
  input  wire logic [5:0]                     minute,
  input  wire logic                           enable_demi,
  input  wire logic [wclm_pkg::ROW_IDX_W-1:0] row,
  output logic      [wclm_pkg::ROW_WIDTH-1:0] row_bits
);

  function automatic wclm_pkg::led_mask_t add_word(input wclm_pkg::led_mask_t m,
                                                   input wclm_pkg::led_word_t w);
    wclm_pkg::led_mask_t r;
    r = m;
    if (w.row <= wclm_pkg::LAST_ROW) begin
      r[w.row] = r[w.row] | w.bits;
    end
    return r;
  endfunction

  wclm_pkg::led_mask_t mask;
  logic [3:0] h12;
  logic [5:0] v;
  logic [2:0] tens;
  logic [3:0] units;

  always_comb begin
    mask  = '0;
    v     = '0;
    tens  = '0;
    units = '0;
    h12   = (hour >= 5'd12) ? 4'(hour - 5'd12) : hour[3:0];

    mask = add_word(mask, wclm_pkg::W_IT_IS);

    // Hour words: midi and minuit carry no heure.
    if (hour == 5'd12) begin
      mask = add_word(mask, wclm_pkg::W_NOON);
    end else begin
      mask = add_word(mask, wclm_pkg::W_HOUR[h12]);
    end
    if (hour != 5'd0 && hour != 5'd12) begin
      if (h12 == 4'd1) begin
        mask = add_word(mask, wclm_pkg::W_HEURE);
      end else begin
        mask = add_word(mask, wclm_pkg::W_HEURES);
      end
    end

    // Minute words; from minute forty the count runs down to the hour.
    if (minute != 6'd0) begin
      if (minute >= wclm_pkg::MOINS_FROM) begin
        mask = add_word(mask, wclm_pkg::W_MOINS);
        v = wclm_pkg::MINUTES_PER_HOUR - minute;
        if (v == 6'd15) begin
          mask = add_word(mask, wclm_pkg::W_LE);
        end
      end else begin
        mask = add_word(mask, wclm_pkg::W_ET_HOUR);
        v = minute;
      end

      if (v == 6'd30 && enable_demi) begin
        mask = add_word(mask, wclm_pkg::W_DEMI);
      end else begin
        if (v > 6'd10 && v <= 6'd16) begin
          mask = add_word(mask, wclm_pkg::W_TEENS[3'(v - 6'd10)]);
        end else begin
          if (v >= 6'd50)      tens = 3'd5;
          else if (v >= 6'd40) tens = 3'd4;
          else if (v >= 6'd30) tens = 3'd3;
          else if (v >= 6'd20) tens = 3'd2;
          else if (v >= 6'd10) tens = 3'd1;
          else                 tens = 3'd0;
          units = 4'(v - (6'(tens) * 6'd10));
          if (tens != 3'd0) begin
            mask = add_word(mask, wclm_pkg::W_TENS[tens]);
          end
          if (units != 4'd0) begin
            if (units == 4'd1 && tens != 3'd0) begin
              mask = add_word(mask, wclm_pkg::W_ET);
            end
            mask = add_word(mask, wclm_pkg::W_UNIT[units - 4'd1]);
          end
        end
        // Quart takes no minute word.
        if (v != 6'd15) begin
          if (v != 6'd1) begin
            mask = add_word(mask, wclm_pkg::W_MINUTES);
          end else begin
            mask = add_word(mask, wclm_pkg::W_MINUTE);
          end
        end
      end
    end

    row_bits = mask[row];
  end

endmodule : wclm_mask

`default_nettype wire
